@@ rtl/agas_pkg.sv @@
// ----------------------------------------------------------------------------
// agas_pkg
// Shared types, register indexes, constants and the control store of the
// two-axis aiming stepper.
// ----------------------------------------------------------------------------
package agas_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FLOOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_CEIL   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_BAND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_STEP     = 3'd4;

    localparam logic [15:0] DEF_SCALE_FLOOR  = 16'd410;
    localparam logic [15:0] DEF_SCALE_CEIL   = 16'd16384;
    localparam logic [7:0]  DEF_SETTLE_BAND  = 8'd3;
    localparam logic [7:0]  DEF_SETTLE_LIMIT = 8'd5;
    localparam logic [7:0]  DEF_MIN_STEP     = 8'd8;

    typedef struct packed {
        logic [15:0] scale_floor;
        logic [15:0] scale_ceil;
        logic [7:0]  settle_band;
        logic [7:0]  settle_limit;
        logic [7:0]  min_step;
    } cfg_t;

    // error magnitude thresholds for the base step
    localparam int BIG_ERR = 50;
    localparam int MID_ERR = 20;

    // base step in twentieths: small, middle, large
    localparam int BASE_X_SMALL = 6;
    localparam int BASE_X_MID   = 8;
    localparam int BASE_X_LARGE = 12;
    localparam int BASE_Y_SMALL = 6;
    localparam int BASE_Y_MID   = 7;
    localparam int BASE_Y_LARGE = 10;

    // gain factors in twentieths
    localparam int GAIN_SHRINK = 16;
    localparam int GAIN_GROW   = 22;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    // microcode
    localparam int PC_W = 4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_SETTLE,
        OP_GAIN_MUL,
        OP_GAIN_SET,
        OP_STEP_MUL,
        OP_APPLY,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t             op;
        logic            axis;
        logic            jump_stop;  // branch to target when the axis is settled
        logic [PC_W-1:0] target;
        logic            wait_out;   // hold here until the output slot is free
        logic            last;
    } uword_t;

    typedef struct packed {
        logic stop;      // settle test says: no step on this axis
        logic out_free;  // output register can take a result this cycle
    } dp_status_t;

    localparam logic [PC_W-1:0] PC_APPLY_X = 4'd4;
    localparam logic [PC_W-1:0] PC_APPLY_Y = 4'd9;

    localparam uword_t UW_IDLE = '{OP_NOP, AXIS_X, 1'b0, '0, 1'b0, 1'b1};

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = UW_IDLE;
        case (pc)
            4'd0:    w = '{OP_SETTLE,   AXIS_X, 1'b1, PC_APPLY_X, 1'b0, 1'b0};
            4'd1:    w = '{OP_GAIN_MUL, AXIS_X, 1'b0, '0,         1'b0, 1'b0};
            4'd2:    w = '{OP_GAIN_SET, AXIS_X, 1'b0, '0,         1'b0, 1'b0};
            4'd3:    w = '{OP_STEP_MUL, AXIS_X, 1'b0, '0,         1'b0, 1'b0};
            4'd4:    w = '{OP_APPLY,    AXIS_X, 1'b0, '0,         1'b0, 1'b0};
            4'd5:    w = '{OP_SETTLE,   AXIS_Y, 1'b1, PC_APPLY_Y, 1'b0, 1'b0};
            4'd6:    w = '{OP_GAIN_MUL, AXIS_Y, 1'b0, '0,         1'b0, 1'b0};
            4'd7:    w = '{OP_GAIN_SET, AXIS_Y, 1'b0, '0,         1'b0, 1'b0};
            4'd8:    w = '{OP_STEP_MUL, AXIS_Y, 1'b0, '0,         1'b0, 1'b0};
            4'd9:    w = '{OP_APPLY,    AXIS_Y, 1'b0, '0,         1'b0, 1'b0};
            4'd10:   w = '{OP_EMIT,     AXIS_X, 1'b0, '0,         1'b1, 1'b1};
            default: w = UW_IDLE;
        endcase
        return w;
    endfunction

endpackage

@@ rtl/adaptive_gain_aim_stepper.sv @@
// ----------------------------------------------------------------------------
// adaptive_gain_aim_stepper
// Two-axis servo aiming stepper with adaptive gain and settle detection.
// ----------------------------------------------------------------------------
// One item in, one result out. A small microprogram runs the x axis and then
// the y axis through one shared multiplier: settle test, gain product, gain
// clamp with the error-times-base product, step product, target. An item is
// taken only once the program for the last one has ended; each axis that
// is settled skips three steps. The single multiplier and the serial walk
// over the two axes set how long an item takes; a result that is not taken
// holds the program at its last step. The result register lets a finished
// result wait while the next item is worked on up to that step.
// Configuration is written through a plain write port; the user must write
// it only while the block is idle, which the block itself does not enforce.
module adaptive_gain_aim_stepper #(
    parameter int ERROR_BITS      = 10,
    parameter int POSITION_BITS   = 16,
    parameter int SCALE_FRAC_BITS = 12,
    localparam int S_TDATA_W = ((2 * ERROR_BITS + 2 * POSITION_BITS + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * POSITION_BITS + 2 + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // error_x, error_y, position_x, position_y
    input  logic [S_TDATA_W-1:0]              s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // move_x, target_x, move_y, target_y
    output logic [M_TDATA_W-1:0]              m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [agas_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [agas_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);
    import agas_pkg::*;

    localparam int EB = ERROR_BITS;
    localparam int PB = POSITION_BITS;

    cfg_t cfg_reg;

    logic                 start, busy;
    uword_t               uw;
    dp_status_t           status;
    logic                 move_x, move_y;
    logic signed [PB-1:0] target_x, target_y;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scale_floor  <= DEF_SCALE_FLOOR;
            cfg_reg.scale_ceil   <= DEF_SCALE_CEIL;
            cfg_reg.settle_band  <= DEF_SETTLE_BAND;
            cfg_reg.settle_limit <= DEF_SETTLE_LIMIT;
            cfg_reg.min_step     <= DEF_MIN_STEP;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_SCALE_FLOOR:  cfg_reg.scale_floor  <= cfg_wr_data;
                CFG_SCALE_CEIL:   cfg_reg.scale_ceil   <= cfg_wr_data;
                CFG_SETTLE_BAND:  cfg_reg.settle_band  <= cfg_wr_data[7:0];
                CFG_SETTLE_LIMIT: cfg_reg.settle_limit <= cfg_wr_data[7:0];
                CFG_MIN_STEP:     cfg_reg.min_step     <= cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    assign s_tready = !busy;
    assign start    = s_tvalid && !busy;

    agas_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .status  (status),
        .uw      (uw),
        .busy    (busy)
    );

    agas_datapath #(
        .ERROR_BITS      (ERROR_BITS),
        .POSITION_BITS   (POSITION_BITS),
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (start),
        .error_x    (s_tdata[EB-1:0]),
        .error_y    (s_tdata[2*EB-1:EB]),
        .position_x (s_tdata[2*EB+PB-1:2*EB]),
        .position_y (s_tdata[2*EB+2*PB-1:2*EB+PB]),
        .cfg        (cfg_reg),
        .uw         (uw),
        .status     (status),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .move_x     (move_x),
        .target_x   (target_x),
        .move_y     (move_y),
        .target_y   (target_y)
    );

    assign m_tdata = M_TDATA_W'({target_y, move_y, target_x, move_x});

endmodule

@@ rtl/agas_sequencer.sv @@
// ----------------------------------------------------------------------------
// agas_sequencer
// Step counter over the control store, with the settle branch and the
// output wait.
// ----------------------------------------------------------------------------
module agas_sequencer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  agas_pkg::dp_status_t status,
    output agas_pkg::uword_t    uw,
    output logic                busy
);
    import agas_pkg::*;

    logic            running_reg, running_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uword_t          word;

    always_comb begin
        word         = ucode(pc_reg);
        running_next = running_reg;
        pc_next      = pc_reg;
        if (!running_reg) begin
            if (start) begin
                running_next = 1'b1;
                pc_next      = '0;
            end
        end else if (word.wait_out && !status.out_free) begin
            pc_next = pc_reg;
        end else if (word.last) begin
            running_next = 1'b0;
        end else if (word.jump_stop && status.stop) begin
            pc_next = word.target;
        end else begin
            pc_next = PC_W'(pc_reg + 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg <= 1'b0;
            pc_reg      <= '0;
        end else begin
            running_reg <= running_next;
            pc_reg      <= pc_next;
        end
    end

    assign uw   = running_reg ? word : UW_IDLE;
    assign busy = running_reg;

endmodule

@@ rtl/agas_datapath.sv @@
// ----------------------------------------------------------------------------
// agas_datapath
// Per-axis state, one shared multiplier, step and target logic, and the
// output register. Each word works on the axis it names; emit takes both.
// ----------------------------------------------------------------------------
module agas_datapath #(
    parameter int ERROR_BITS      = 10,
    parameter int POSITION_BITS   = 16,
    parameter int SCALE_FRAC_BITS = 12
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             load,
    input  logic signed [ERROR_BITS-1:0]     error_x,
    input  logic signed [ERROR_BITS-1:0]     error_y,
    input  logic signed [POSITION_BITS-1:0]  position_x,
    input  logic signed [POSITION_BITS-1:0]  position_y,
    input  agas_pkg::cfg_t                   cfg,
    input  agas_pkg::uword_t                 uw,
    output agas_pkg::dp_status_t             status,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             move_x,
    output logic signed [POSITION_BITS-1:0]  target_x,
    output logic                             move_y,
    output logic signed [POSITION_BITS-1:0]  target_y
);
    import agas_pkg::*;

    localparam int EB = ERROR_BITS;
    localparam int PB = POSITION_BITS;
    localparam int F  = SCALE_FRAC_BITS;

    localparam int PROD1_W = EB + F;                      // |e| * base
    localparam int PROD_W  = EB + F + 16;                 // |e| * base * scale
    localparam int MUL_A_W = (PROD1_W > 16) ? PROD1_W : 16;
    localparam int MUL_B_W = (F + 1 > 16) ? F + 1 : 16;
    localparam int MUL_W   = MUL_A_W + MUL_B_W;
    localparam int MAG_W   = (PROD_W > 8 + 2 * F) ? PROD_W : 8 + 2 * F;
    localparam int IP_W    = MAG_W - 2 * F;
    localparam int SUM_W   = ((PB > IP_W) ? PB : IP_W) + 2;
    localparam int CMP_W   = (EB > 8) ? EB : 8;

    localparam longint unsigned ONE_Q = 64'd1 << F;

    localparam logic [MUL_B_W-1:0] C_SHRINK = MUL_B_W'((GAIN_SHRINK * ONE_Q + 10) / 20);
    localparam logic [MUL_B_W-1:0] C_GROW   = MUL_B_W'((GAIN_GROW * ONE_Q + 10) / 20);
    localparam logic [MUL_B_W-1:0] B_X_S    = MUL_B_W'((BASE_X_SMALL * ONE_Q + 10) / 20);
    localparam logic [MUL_B_W-1:0] B_X_M    = MUL_B_W'((BASE_X_MID * ONE_Q + 10) / 20);
    localparam logic [MUL_B_W-1:0] B_X_L    = MUL_B_W'((BASE_X_LARGE * ONE_Q + 10) / 20);
    localparam logic [MUL_B_W-1:0] B_Y_S    = MUL_B_W'((BASE_Y_SMALL * ONE_Q + 10) / 20);
    localparam logic [MUL_B_W-1:0] B_Y_M    = MUL_B_W'((BASE_Y_MID * ONE_Q + 10) / 20);
    localparam logic [MUL_B_W-1:0] B_Y_L    = MUL_B_W'((BASE_Y_LARGE * ONE_Q + 10) / 20);

    localparam logic [15:0] SCALE_ONE = (F >= 16) ? 16'hFFFF : 16'(ONE_Q);

    localparam logic signed [SUM_W-1:0] POS_HI = {{(SUM_W-PB+1){1'b0}}, {(PB-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_LO = {{(SUM_W-PB+1){1'b1}}, {(PB-1){1'b0}}};

    // captured item
    logic signed [EB-1:0] err_reg [2];
    logic signed [PB-1:0] pos_reg [2];

    // per-axis state
    logic [15:0]          scale_reg [2];
    logic signed [EB-1:0] prev_reg  [2];
    logic                 over_reg  [2];
    logic [7:0]           count_reg [2];

    // working registers
    logic [EB-1:0]    ae_reg;
    logic             stop_reg;
    logic             flip_reg;
    logic             upd_reg;
    logic [MUL_W-1:0] mul_reg;

    logic                 res_move_reg   [2];
    logic signed [PB-1:0] res_target_reg [2];

    logic                 m_valid_reg;
    logic                 out_move_x_reg, out_move_y_reg;
    logic signed [PB-1:0] out_target_x_reg, out_target_y_reg;

    // current axis
    logic                 ax;
    logic signed [EB-1:0] e_cur;
    logic signed [PB-1:0] p_cur;
    logic [EB-1:0]        ae;
    logic [15:0]          scale_cur;

    logic       settle_hit, stop_now;
    logic [7:0] count_inc, count_new;
    logic       flip;

    logic [MUL_B_W-1:0] base;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_W-1:0]   mul_p;

    logic [16:0] gain_s;
    logic [15:0] scale_new;

    logic [MAG_W-1:0]       mag_raw, min_mag, mag;
    logic                   step_nz, fr_nz, dir_up;
    logic [IP_W-1:0]        ip;
    logic signed [SUM_W-1:0] p_s, ip_s, fr_s, n_up, n_dn, n_sel, t_sum;
    logic signed [PB-1:0]   t_sat;
    logic                   out_free;

    always_comb begin
        ax        = uw.axis;
        e_cur     = err_reg[ax];
        p_cur     = pos_reg[ax];
        ae        = e_cur[EB-1] ? EB'(~e_cur + 1'b1) : EB'(e_cur);
        scale_cur = scale_reg[ax];

        // settle test
        settle_hit = CMP_W'(ae) <= CMP_W'(cfg.settle_band);
        count_inc  = (count_reg[ax] == 8'hFF) ? 8'hFF : 8'(count_reg[ax] + 1'b1);
        count_new  = settle_hit ? count_inc : 8'd0;
        stop_now   = settle_hit && (count_inc > cfg.settle_limit);

        // sign flip against the stored error, both nonzero
        flip = (prev_reg[ax] != '0) && (e_cur != '0) && (prev_reg[ax][EB-1] != e_cur[EB-1]);

        // base step by error size, from the magnitude captured at settle
        if (ae_reg > EB'(BIG_ERR)) begin
            base = (ax == AXIS_Y) ? B_Y_L : B_X_L;
        end else if (ae_reg > EB'(MID_ERR)) begin
            base = (ax == AXIS_Y) ? B_Y_M : B_X_M;
        end else begin
            base = (ax == AXIS_Y) ? B_Y_S : B_X_S;
        end

        case (uw.op)
            OP_GAIN_MUL: begin
                mul_a = MUL_A_W'(scale_cur);
                mul_b = flip ? C_SHRINK : C_GROW;
            end
            OP_GAIN_SET: begin
                mul_a = MUL_A_W'(ae_reg);
                mul_b = base;
            end
            OP_STEP_MUL: begin
                mul_a = MUL_A_W'(mul_reg[PROD1_W-1:0]);
                mul_b = MUL_B_W'(scale_cur);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

        // gain clamp: each side uses only its own bound
        gain_s = mul_reg[F+16:F];
        if (flip_reg) begin
            scale_new = (gain_s < {1'b0, cfg.scale_floor}) ? cfg.scale_floor : gain_s[15:0];
        end else begin
            scale_new = (gain_s > {1'b0, cfg.scale_ceil}) ? cfg.scale_ceil : gain_s[15:0];
        end

        // step magnitude in Q(2F), raised to min_step when nonzero
        mag_raw = MAG_W'(mul_reg[PROD_W-1:0]);
        min_mag = MAG_W'(cfg.min_step) << (2 * F);
        step_nz = (mag_raw != '0);
        mag     = (step_nz && (mag_raw < min_mag)) ? min_mag : mag_raw;
        ip      = mag[MAG_W-1:2*F];
        fr_nz   = |mag[2*F-1:0];

        // y moves against its error
        dir_up = (ax == AXIS_Y) ? e_cur[EB-1] : !e_cur[EB-1];

        p_s   = SUM_W'(p_cur);
        ip_s  = SUM_W'(ip);
        fr_s  = {{(SUM_W-1){1'b0}}, fr_nz};
        n_up  = p_s + ip_s;
        n_dn  = p_s - ip_s - fr_s;
        n_sel = dir_up ? n_up : n_dn;
        // truncate toward zero: a negative result with a fraction moves up one
        t_sum = n_sel + (n_sel[SUM_W-1] ? fr_s : '0);
        if (t_sum > POS_HI) begin
            t_sat = POS_HI[PB-1:0];
        end else if (t_sum < POS_LO) begin
            t_sat = POS_LO[PB-1:0];
        end else begin
            t_sat = t_sum[PB-1:0];
        end

        out_free = !m_valid_reg || m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                scale_reg[i] <= SCALE_ONE;
                prev_reg[i]  <= '0;
                over_reg[i]  <= 1'b0;
                count_reg[i] <= '0;
            end
            stop_reg    <= 1'b0;
            flip_reg    <= 1'b0;
            upd_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                err_reg[0] <= error_x;
                err_reg[1] <= error_y;
                pos_reg[0] <= position_x;
                pos_reg[1] <= position_y;
            end

            case (uw.op)
                OP_SETTLE: begin
                    count_reg[ax] <= count_new;
                    stop_reg      <= stop_now;
                    ae_reg        <= ae;
                end
                OP_GAIN_MUL: begin
                    flip_reg <= flip;
                    upd_reg  <= flip || !over_reg[ax];
                    mul_reg  <= mul_p;
                end
                OP_GAIN_SET: begin
                    if (upd_reg) begin
                        scale_reg[ax] <= scale_new;
                    end
                    if (flip_reg) begin
                        over_reg[ax] <= 1'b1;
                    end
                    mul_reg <= mul_p;
                end
                OP_STEP_MUL: begin
                    mul_reg <= mul_p;
                end
                OP_APPLY: begin
                    if (stop_reg) begin
                        res_move_reg[ax]   <= 1'b0;
                        res_target_reg[ax] <= p_cur;
                    end else begin
                        prev_reg[ax]       <= e_cur;
                        res_move_reg[ax]   <= step_nz;
                        res_target_reg[ax] <= step_nz ? t_sat : p_cur;
                    end
                end
                default: begin
                end
            endcase

            if (uw.op == OP_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        if (uw.op == OP_EMIT && out_free) begin
            out_move_x_reg   <= res_move_reg[0];
            out_target_x_reg <= res_target_reg[0];
            out_move_y_reg   <= res_move_reg[1];
            out_target_y_reg <= res_target_reg[1];
        end
    end

    assign status.stop     = stop_now;
    assign status.out_free = out_free;
    assign m_valid  = m_valid_reg;
    assign move_x   = out_move_x_reg;
    assign target_x = out_target_x_reg;
    assign move_y   = out_move_y_reg;
    assign target_y = out_target_y_reg;

endmodule

@@ rtl/agas_checker.sv @@
// ----------------------------------------------------------------------------
// agas_checker
// Port-level checks of the aiming stepper, bound to the top level.
// ----------------------------------------------------------------------------
module agas_checker #(
    parameter int M_TDATA_W = 40
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // a stalled result holds its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

    // one item at a time: after an accepted item the input side is closed
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is still in work");

    // the program needs several steps before a new result can show up
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> ##2 !$rose(m_tvalid))
        else $error("result appeared too soon after an item");

    // reset empties the output register
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind adaptive_gain_aim_stepper agas_checker #(
    .M_TDATA_W (M_TDATA_W)
) u_agas_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
